// File: rtl/qor_pkg.sv
// ----------------------------------------------------------------------------
// qor_pkg
// Shared types, constants and tables for the quaternion orientation rotator.
// ----------------------------------------------------------------------------
package qor_pkg;

    localparam int unsigned CORDIC_STEPS = 16;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [15:0] UNIT_ONE = 16'sd16384;
    localparam logic signed [18:0] TURN_UNITS = 19'sd92160;
    localparam logic signed [18:0] HALF_TURN_UNITS = 19'sd46080;
    localparam logic signed [18:0] QUARTER_TURN_UNITS = 19'sd23040;
    localparam logic [14:0] TOL_RESET = 15'd819;

    // Datapath commands
    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_CORDIC,
        CMD_SINCOS,
        CMD_LOCAL,
        CMD_MAC,
        CMD_SQ,
        CMD_CHECK,
        CMD_SQRT,
        CMD_DIV,
        CMD_COMMIT
    } cmd_code_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_SINCOS,
        ST_LOCAL,
        ST_MAC,
        ST_SQ,
        ST_CHECK,
        ST_SQRT,
        ST_DIV,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        cmd_code_t   code;
        logic [5:0]  cnt;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_reset;
        logic renorm;
        logic out_busy;
    } dp_status_t;

    // Arctangent of 2^-i in 2^-14 degree
    function automatic logic [19:0] atan_q14(input logic [3:0] i);
        logic [19:0] v;
        case (i)
            4'd0:    v = 20'd737280;
            4'd1:    v = 20'd435242;
            4'd2:    v = 20'd229970;
            4'd3:    v = 20'd116736;
            4'd4:    v = 20'd58595;
            4'd5:    v = 20'd29326;
            4'd6:    v = 20'd14667;
            4'd7:    v = 20'd7334;
            4'd8:    v = 20'd3667;
            4'd9:    v = 20'd1833;
            4'd10:   v = 20'd917;
            4'd11:   v = 20'd458;
            4'd12:   v = 20'd229;
            4'd13:   v = 20'd115;
            4'd14:   v = 20'd57;
            default: v = 20'd29;
        endcase
        return v;
    endfunction

    // Sign of term t in product component j (1 = subtract)
    function automatic logic term_neg(input logic [1:0] j, input logic [1:0] t);
        logic [15:0] tbl;
        tbl = 16'b0100_0010_1000_1110;
        return tbl[{j, t}];
    endfunction

    // Saturate to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [43:0] v);
        logic signed [15:0] r;
        if (v > 44'sd32767)
            r = 16'sh7FFF;
        else if (v < -44'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// File: rtl/qor_ctrl.sv
// ----------------------------------------------------------------------------
// qor_ctrl
// Sequencer: steps the datapath through CORDIC, product, magnitude check,
// square root and division for a rotation word; a reset word goes to commit.
// ----------------------------------------------------------------------------
module qor_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  qor_pkg::dp_status_t status,
    output qor_pkg::ctrl_cmd_t  cmd
);
    import qor_pkg::*;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd.code   = CMD_NOP;
        cmd.cnt    = cnt_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.code   = CMD_LOAD;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (status.is_reset)
                    state_next = ST_COMMIT;
                else
                begin
                    cmd.code = CMD_CORDIC;
                    if (cnt_reg == 6'd15)
                        state_next = ST_SINCOS;
                end
            end
            ST_SINCOS:
            begin
                cmd.code   = CMD_SINCOS;
                state_next = ST_LOCAL;
            end
            ST_LOCAL:
            begin
                cmd.code = CMD_LOCAL;
                if (cnt_reg == 6'd2)
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.code = CMD_MAC;
                if (cnt_reg == 6'd15)
                    state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.code = CMD_SQ;
                if (cnt_reg == 6'd3)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.code   = CMD_CHECK;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (!status.renorm)
                    state_next = ST_COMMIT;
                else
                begin
                    cmd.code = CMD_SQRT;
                    if (cnt_reg == 6'd20)
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.code = CMD_DIV;
                if (cnt_reg == 6'd63)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.code   = CMD_COMMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cnt_next = (state_next != state_reg) ? 6'd0 : cnt_reg + 6'd1;
    end

endmodule

// File: rtl/qor_datapath.sv
// ----------------------------------------------------------------------------
// qor_datapath
// Orientation storage, CORDIC, shared multiplier/accumulator, square root
// and divider, and the output word register.
// ----------------------------------------------------------------------------
module qor_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  qor_pkg::ctrl_cmd_t  cmd,
    output qor_pkg::dp_status_t status,
    input  logic [71:0]         s_tdata,
    input  logic                s_tuser,
    input  logic                cfg_wr_en,
    input  logic [14:0]         cfg_wr_data,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [63:0]         m_tdata,
    output logic                m_tuser
);
    import qor_pkg::*;

    // Control and status registers
    logic        op_reg;
    logic        renorm_reg;
    logic        out_valid_reg;
    logic [14:0] tol_reg;

    // Payload registers
    logic signed [15:0] q_reg [0:3];
    logic signed [15:0] ax_reg [0:2];
    logic signed [16:0] ang_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [23:0] cz_reg;
    logic               neg_reg;
    logic signed [17:0] s_reg;
    logic signed [17:0] l_reg [0:3];
    logic signed [19:0] r_reg [0:3];
    logic signed [43:0] acc_reg;
    logic [41:0]        sq_reg;
    logic [41:0]        n_reg, res_reg;
    logic [20:0]        m_reg;
    logic [20:0]        rem_reg;
    logic [15:0]        quot_reg;
    logic               flag_reg;

    // Angle fold into +-90 degrees (half angle in 1/256 degree)
    logic signed [18:0] h1, h2, h3;
    logic               hneg;
    always_comb
    begin
        h1   = 19'(ang_reg);
        if (h1 < 19'sd0)
            h1 = h1 + TURN_UNITS;
        h2   = (h1 > HALF_TURN_UNITS) ? h1 - TURN_UNITS : h1;
        h3   = h2;
        hneg = 1'b0;
        if (h2 > QUARTER_TURN_UNITS)
        begin
            h3   = h2 - HALF_TURN_UNITS;
            hneg = 1'b1;
        end
        else if (h2 < -QUARTER_TURN_UNITS)
        begin
            h3   = h2 + HALF_TURN_UNITS;
            hneg = 1'b1;
        end
    end

    // CORDIC step
    logic [3:0]         ci;
    logic signed [33:0] cdx, cdy;
    logic signed [23:0] catan;
    logic signed [33:0] cos_r, sin_r;
    assign ci    = cmd.cnt[3:0];
    assign cdx   = cy_reg >>> ci;
    assign cdy   = cx_reg >>> ci;
    assign catan = 24'(signed'({1'b0, atan_q14(ci)}));
    assign cos_r = (cx_reg + 34'sd32768) >>> 16;
    assign sin_r = (cy_reg + 34'sd32768) >>> 16;

    // Shared multiplier operand select
    logic [1:0]         mj, mt, ridx;
    logic signed [19:0] mul_a, mul_b;
    logic signed [39:0] mul_p;
    logic               first, msub;
    logic signed [19:0] r_sel;
    assign mj    = cmd.cnt[3:2];
    assign mt    = cmd.cnt[1:0];
    assign ridx  = (cmd.code == CMD_DIV) ? cmd.cnt[5:4] : cmd.cnt[1:0];
    assign r_sel = r_reg[ridx];
    always_comb
    begin
        mul_a = 20'sd0;
        mul_b = 20'sd0;
        msub  = 1'b0;
        first = (cmd.cnt[1:0] == 2'd0);
        case (cmd.code)
            CMD_LOCAL:
            begin
                mul_a = 20'(ax_reg[cmd.cnt[1:0]]);
                mul_b = 20'(s_reg);
            end
            CMD_MAC:
            begin
                mul_a = 20'(l_reg[mt]);
                mul_b = 20'(q_reg[mj ^ mt]);
                msub  = term_neg(mj, mt);
            end
            CMD_SQ:
            begin
                mul_a = r_sel;
                mul_b = r_sel;
            end
            default:
            begin
                mul_a = 20'sd0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    logic signed [43:0] acc_base, acc_sum, loc_rnd, acc_rnd;
    assign acc_base = first ? 44'sd0 : acc_reg;
    assign acc_sum  = msub ? acc_base - 44'(mul_p) : acc_base + 44'(mul_p);
    assign loc_rnd  = (44'(mul_p) + 44'sd8192) >>> 14;
    assign acc_rnd  = (acc_sum + 44'sd8192) >>> 14;

    // Magnitude check
    logic [41:0] dev, lim;
    assign dev = (sq_reg > 42'h1000_0000) ? sq_reg - 42'h1000_0000
                                          : 42'h1000_0000 - sq_reg;
    assign lim = {13'd0, tol_reg, 14'd0};

    // Square root step, two bits per step
    logic [41:0] n_cur, res_cur, sq_bit, trial, n_nx, res_nx;
    assign n_cur   = (cmd.cnt == 6'd0) ? sq_reg : n_reg;
    assign res_cur = (cmd.cnt == 6'd0) ? 42'd0 : res_reg;
    assign sq_bit  = 42'd1 << (6'd40 - {cmd.cnt[4:0], 1'b0});
    assign trial   = res_cur + sq_bit;
    always_comb
    begin
        if (n_cur >= trial)
        begin
            n_nx   = n_cur - trial;
            res_nx = (res_cur >> 1) + sq_bit;
        end
        else
        begin
            n_nx   = n_cur;
            res_nx = res_cur >> 1;
        end
    end

    // Restoring divide step: round(|r| * 2^14 / m), one quotient bit per step
    logic [3:0]  db;
    logic [19:0] mag;
    logic [33:0] numer;
    logic [20:0] rem_cur, rem_sh, rem_nx;
    logic        dge;
    logic [15:0] quot_nx;
    assign db      = cmd.cnt[3:0];
    assign mag     = r_sel[19] ? 20'(-r_sel) : 20'(r_sel);
    assign numer   = {mag, 14'd0} + 34'(m_reg >> 1);
    assign rem_cur = (db == 4'd0) ? 21'(numer[33:16]) : rem_reg;
    assign rem_sh  = {rem_cur[19:0], numer[4'd15 - db]};
    assign dge     = (rem_sh >= m_reg);
    assign rem_nx  = dge ? rem_sh - m_reg : rem_sh;
    assign quot_nx = {quot_reg[14:0], dge};

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= 1'b0;
            renorm_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            tol_reg       <= TOL_RESET;
            q_reg[0]      <= UNIT_ONE;
            q_reg[1]      <= 16'sd0;
            q_reg[2]      <= 16'sd0;
            q_reg[3]      <= 16'sd0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                tol_reg <= cfg_wr_data;
            if (cmd.code == CMD_LOAD)
            begin
                op_reg     <= s_tuser;
                renorm_reg <= 1'b0;
            end
            if (cmd.code == CMD_CHECK)
                renorm_reg <= (dev > lim);
            if (cmd.code == CMD_COMMIT)
            begin
                out_valid_reg <= 1'b1;
                if (op_reg)
                begin
                    q_reg[0] <= UNIT_ONE;
                    q_reg[1] <= 16'sd0;
                    q_reg[2] <= 16'sd0;
                    q_reg[3] <= 16'sd0;
                    flag_reg <= 1'b0;
                end
                else
                begin
                    for (int k = 0; k < 4; k++)
                        q_reg[k] <= sat16(44'(r_reg[k]));
                    flag_reg <= renorm_reg;
                end
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.code)
            CMD_LOAD:
            begin
                ax_reg[0] <= s_tdata[15:0];
                ax_reg[1] <= s_tdata[31:16];
                ax_reg[2] <= s_tdata[47:32];
                ang_reg   <= s_tdata[64:48];
            end
            CMD_CORDIC:
            begin
                if (cmd.cnt == 6'd0)
                begin
                    // first step starts from the folded angle
                    cx_reg  <= CORDIC_GAIN - ((h3 >= 19'sd0) ? 34'sd0 : 34'sd0);
                    cy_reg  <= (h3 >= 19'sd0) ? (CORDIC_GAIN >>> 0) : -CORDIC_GAIN;
                    cz_reg  <= (h3 >= 19'sd0) ? 24'(h3) * 24'sd64 - catan
                                              : 24'(h3) * 24'sd64 + catan;
                    neg_reg <= hneg;
                end
                else if (cz_reg >= 24'sd0)
                begin
                    cx_reg <= cx_reg - cdx;
                    cy_reg <= cy_reg + cdy;
                    cz_reg <= cz_reg - catan;
                end
                else
                begin
                    cx_reg <= cx_reg + cdx;
                    cy_reg <= cy_reg - cdy;
                    cz_reg <= cz_reg + catan;
                end
            end
            CMD_SINCOS:
            begin
                l_reg[0] <= neg_reg ? -cos_r[17:0] : cos_r[17:0];
                s_reg    <= neg_reg ? -sin_r[17:0] : sin_r[17:0];
            end
            CMD_LOCAL:
            begin
                l_reg[2'(cmd.cnt[1:0] + 2'd1)] <= 18'(sat16(loc_rnd));
            end
            CMD_MAC:
            begin
                acc_reg <= acc_sum;
                if (mt == 2'd3)
                    r_reg[mj] <= acc_rnd[19:0];
            end
            CMD_SQ:
            begin
                acc_reg <= acc_sum;
                if (cmd.cnt[1:0] == 2'd3)
                    sq_reg <= acc_sum[41:0];
            end
            CMD_SQRT:
            begin
                n_reg   <= n_nx;
                res_reg <= res_nx;
                if (cmd.cnt == 6'd20)
                    m_reg <= res_nx[20:0];
            end
            CMD_DIV:
            begin
                rem_reg  <= rem_nx;
                quot_reg <= quot_nx;
                if (db == 4'd15 && m_reg != 21'd0)
                    r_reg[cmd.cnt[5:4]] <= r_sel[19] ? -20'(quot_nx) : 20'(quot_nx);
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign status.is_reset = op_reg;
    assign status.renorm   = renorm_reg;
    assign status.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {q_reg[3], q_reg[2], q_reg[1], q_reg[0]};
    assign m_tuser  = flag_reg;

endmodule

// File: rtl/quaternion_orientation_rotate.sv
// ----------------------------------------------------------------------------
// quaternion_orientation_rotate
// Keeps an orientation quaternion and applies axis/angle rotations to it.
// ----------------------------------------------------------------------------
// The block takes one word at a time. A rotation runs the CORDIC, the product
// and the magnitude check, and when the product is renormalized also 21 square
// root steps plus 16 divide steps per component on one divider; a reset word
// goes straight to commit. The 16-step CORDIC and the single shared multiplier
// set the base latency. A finished result waits in the output register, which
// is the stored orientation itself, while the next word is accepted.
module quaternion_orientation_rotate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // axis_x, axis_y, axis_z, angle[16:0], zero pad
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tuser,   // renormalized
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data
);
    import qor_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    qor_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qor_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a word while busy");

    // A result appears only from a commit
    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.code == CMD_COMMIT))
        else $error("result without commit");

    // CORDIC runs its last step into the sine/cosine capture
    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == CMD_CORDIC && cmd.cnt == 6'd15) |=> cmd.code == CMD_SINCOS)
        else $error("CORDIC sequence broken");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion orientation rotator: directed table
// then random rotate/reset words, checked against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import qor_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;
    localparam int N_RANDOM = 730;

    typedef struct {
        logic               op;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [16:0] angle;
    } rot_word_t;

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               renorm;
    } quat_res_t;

    typedef struct {
        rot_word_t word;
        logic      has_fixed;
        quat_res_t fixed;
    } table_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // axis_x, axis_y, axis_z, angle[16:0], zero pad
    logic        s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // quat_w, quat_x, quat_y, quat_z
    logic        m_tuser;   // renormalized
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;

    // predictor state
    longint orient_q[4];
    longint tol_q;

    quat_res_t expected_quats[$];
    int        error_count;
    bit        quiet_tail;
    bit        hold_off;
    int        idle_cycles;
    int        stall_left;

    quaternion_orientation_rotate dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #5 clk = ~clk;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint rnd14(longint v);
        return (v + 8192) >>> 14;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint res, bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > n) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >>> 1) + bitv;
            end
            else
                res = res >>> 1;
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    // CORDIC sine/cosine of the half angle
    task automatic half_sincos(input longint h, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit neg;
        neg = 0;
        x = CORDIC_GAIN;
        y = 0;
        if (h < 0) h += TURN_UNITS;
        if (h >= TURN_UNITS) h -= TURN_UNITS;
        if (h > HALF_TURN_UNITS) h -= TURN_UNITS;
        if (h > QUARTER_TURN_UNITS) begin h -= HALF_TURN_UNITS; neg = 1; end
        else if (h < -QUARTER_TURN_UNITS) begin h += HALF_TURN_UNITS; neg = 1; end
        z = h * 64;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin x -= dx; y += dy; z -= longint'(atan_q14(4'(i))); end
            else        begin x += dx; y -= dy; z += longint'(atan_q14(4'(i))); end
        end
        c = (x + 32768) >>> 16;
        s = (y + 32768) >>> 16;
        if (neg) begin c = -c; s = -s; end
    endtask

    // Apply one word to the orientation and return the new quaternion
    task automatic predict_orientation(input rot_word_t wd, output quat_res_t res);
        longint c, s, lw, lx, ly, lz, sq, dev, m, mag, q;
        longint r[4];
        bit flag;
        flag = 0;
        if (wd.op) begin
            orient_q = '{16384, 0, 0, 0};
        end
        else begin
            half_sincos(longint'(wd.angle), c, s);
            lw = c;
            lx = clamp16(rnd14(longint'(wd.ax) * s));
            ly = clamp16(rnd14(longint'(wd.ay) * s));
            lz = clamp16(rnd14(longint'(wd.az) * s));
            r[0] = rnd14(lw*orient_q[0] - lx*orient_q[1] - ly*orient_q[2] - lz*orient_q[3]);
            r[1] = rnd14(lw*orient_q[1] + lx*orient_q[0] + ly*orient_q[3] - lz*orient_q[2]);
            r[2] = rnd14(lw*orient_q[2] - lx*orient_q[3] + ly*orient_q[0] + lz*orient_q[1]);
            r[3] = rnd14(lw*orient_q[3] + lx*orient_q[2] - ly*orient_q[1] + lz*orient_q[0]);
            sq = 0;
            for (int k = 0; k < 4; k++) sq += r[k] * r[k];
            dev = sq > (64'sd1 <<< 28) ? sq - (64'sd1 <<< 28) : (64'sd1 <<< 28) - sq;
            if (dev > (tol_q <<< 14)) begin
                flag = 1;
                m = int_sqrt(sq);
                if (m != 0) begin
                    for (int k = 0; k < 4; k++) begin
                        mag = r[k] < 0 ? -r[k] : r[k];
                        q = ((mag <<< 14) + (m >>> 1)) / m;
                        r[k] = r[k] < 0 ? -q : q;
                    end
                end
            end
            for (int k = 0; k < 4; k++) orient_q[k] = clamp16(r[k]);
        end
        res.w = 16'(orient_q[0]);
        res.x = 16'(orient_q[1]);
        res.y = 16'(orient_q[2]);
        res.z = 16'(orient_q[3]);
        res.renorm = flag;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Offer one word, wait for acceptance
    task automatic send_word(input rot_word_t wd, input bit allow_gap);
        quat_res_t res;
        int gap;
        if (allow_gap && !quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= wd.op;
        s_tdata  <= {7'd0, wd.angle, wd.az, wd.ay, wd.ax};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_orientation(wd, res);
        expected_quats.push_back(res);
    endtask

    task automatic drain_idle();
        s_tvalid <= 1'b0;
        while (expected_quats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [14:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tol_q = v;
    endtask

    function automatic rot_word_t rand_word();
        rot_word_t wd;
        int sel;
        wd.op = ($urandom_range(0, 19) == 0);
        sel = $urandom_range(0, 9);
        wd.ax = 16'($urandom);
        wd.ay = 16'($urandom);
        wd.az = 16'($urandom);
        if (sel < 6) begin
            // mostly near-unit axes keep the orientation meaningful
            wd.ax = 16'($signed($urandom_range(0, 32768)) - 16384);
            wd.ay = 16'($signed($urandom_range(0, 16384)) - 8192);
            wd.az = 16'($signed($urandom_range(0, 16384)) - 8192);
        end
        if (sel < 8)
            wd.angle = 17'($signed($urandom_range(0, 92160)) - 46080);
        else
            wd.angle = 17'($urandom);
        return wd;
    endfunction

    // Directed rows
    table_row_t dir_rows[$];

    task automatic add_row(input logic op, input int ax, input int ay, input int az,
                           input int ang, input bit fixed, input quat_res_t f);
        table_row_t row;
        row.word.op = op;
        row.word.ax = 16'(ax);
        row.word.ay = 16'(ay);
        row.word.az = 16'(az);
        row.word.angle = 17'(ang);
        row.has_fixed = fixed;
        row.fixed = f;
        dir_rows.push_back(row);
    endtask

    // Result checker
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_quats.size() == 0) begin
                report_mismatch("unexpected result word", 1, 0);
            end
            else begin
                quat_res_t e;
                e = expected_quats.pop_front();
                if ($signed(m_tdata[15:0]) != e.w) report_mismatch("quat_w", $signed(m_tdata[15:0]), e.w);
                if ($signed(m_tdata[31:16]) != e.x) report_mismatch("quat_x", $signed(m_tdata[31:16]), e.x);
                if ($signed(m_tdata[47:32]) != e.y) report_mismatch("quat_y", $signed(m_tdata[47:32]), e.y);
                if ($signed(m_tdata[63:48]) != e.z) report_mismatch("quat_z", $signed(m_tdata[63:48]), e.z);
                if (m_tuser != e.renorm) report_mismatch("renormalized", m_tuser, e.renorm);
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_off)
            m_tready <= 1'b0;
        else if (stall_left > 0 && !quiet_tail) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog on cycles without any accepted word
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        quat_res_t f;
        quat_res_t ident;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        quiet_tail = 0;
        hold_off = 0;
        orient_q = '{16384, 0, 0, 0};
        tol_q = TOL_RESET;
        ident = '{w: 16384, x: 0, y: 0, z: 0, renorm: 0};
        f = ident;

        // directed table: identity checks typed in, the rest predicted
        add_row(1, 0, 0, 0, 0, 1, ident);
        add_row(0, 16384, 0, 0, 0, 0, f);
        add_row(0, 16384, 0, 0, 11520, 0, f);
        add_row(0, 0, 16384, 0, -11520, 0, f);
        add_row(0, 0, 0, 16384, 23040, 0, f);
        add_row(0, 0, 0, 16384, 46080, 0, f);
        add_row(0, 16384, 0, 0, -46080, 0, f);
        add_row(0, 32767, 32767, 32767, 65535, 0, f);
        add_row(0, -32768, -32768, -32768, -65536, 0, f);
        add_row(1, -32768, 32767, 0, -65536, 1, ident);
        add_row(0, -32768, 0, 0, 46079, 0, f);
        add_row(0, 0, 0, 0, 46080, 0, f);   // zero axis: only the cosine term remains
        add_row(0, 16384, 0, 0, 1000, 0, f); // small rotation about x
        add_row(1, 0, 0, 0, 0, 1, ident);
        add_row(0, 9459, 9459, 9459, 23039, 0, f);
        add_row(0, 16384, 16384, 0, -23041, 0, f);
        add_row(0, 0, 0, 16384, 1, 0, f);
        add_row(0, 0, 0, 16384, -1, 0, f);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].word, 1'b0);
            if (dir_rows[i].has_fixed)
                expected_quats[$] = dir_rows[i].fixed;
        end
        drain_idle();

        // tolerance sweep, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_tolerance(15'd0);
                1: write_tolerance(15'h7FFF);
                2: write_tolerance(15'd16384);
                3: write_tolerance(15'($urandom_range(1, 2000)));
                default: write_tolerance(TOL_RESET);
            endcase
            if (ph == 1) begin
                // long receiver hold-off while the sender keeps offering
                fork
                    begin
                        hold_off = 1;
                        repeat (400) @(posedge clk);
                        hold_off = 0;
                    end
                    for (int n = 0; n < 10; n++) send_word(rand_word(), 1'b0);
                join
            end
            if (ph == 4) quiet_tail = 1;
            for (int n = 0; n < N_RANDOM / 5; n++)
                send_word(rand_word(), 1'b1);
            drain_idle();
        end

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/qor_pkg.sv
rtl/qor_ctrl.sv
rtl/qor_datapath.sv
rtl/quaternion_orientation_rotate.sv
sim/tb_top.sv
